// File: sv/sine_cosine_table_interp_core_assert.svh
// Assertion macros for the sine/cosine core.
// All checks are clocked on i_clk and switched off while i_rst_n is low.
`ifndef SINE_COSINE_TABLE_INTERP_CORE_ASSERT_SVH
`define SINE_COSINE_TABLE_INTERP_CORE_ASSERT_SVH

// Check that a condition holds at every sampled edge.
`define SCT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a consequence follows the antecedent, delayed by dly edges.
`define SCT_ASSERT_AFTER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// File: sv/sct_pkg.sv
`timescale 1ns / 1ps

package sct_pkg;

    localparam int unsigned AngleW   = 16;
    localparam int unsigned ValueW   = 16;
    localparam int unsigned SegW     = 5;
    localparam int unsigned FracW    = 10;
    localparam int unsigned IdxW     = SegW + 1;
    // Neighbouring table entries differ by at most 3212, so 13 bits carry the step.
    localparam int unsigned DiffW    = 13;
    // |step * frac| stays below 2^22.
    localparam int unsigned ProdW    = DiffW + FracW;

    localparam logic [AngleW-1:0] QuarterTurn = 16'd16384;

    typedef logic        [AngleW-1:0] t_phase;
    typedef logic signed [ValueW-1:0] t_value;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic        [FracW-1:0]  t_frac;

    // Lookup stage output, handed to the interpolation stages.
    typedef struct packed {
        logic   valid;
        logic   negate;
        t_value y0;
        t_diff  diff;
        t_frac  frac;
    } t_seg;

    // Half-wave sine table, 33 points over 0..pi, Q15.
    function automatic t_value sct_half_wave(input logic [IdxW-1:0] idx);
        t_value v;
        case (idx)
            6'd0:    v = 16'sd0;
            6'd1:    v = 16'sd3212;
            6'd2:    v = 16'sd6393;
            6'd3:    v = 16'sd9512;
            6'd4:    v = 16'sd12539;
            6'd5:    v = 16'sd15446;
            6'd6:    v = 16'sd18204;
            6'd7:    v = 16'sd20787;
            6'd8:    v = 16'sd23170;
            6'd9:    v = 16'sd25329;
            6'd10:   v = 16'sd27245;
            6'd11:   v = 16'sd28898;
            6'd12:   v = 16'sd30273;
            6'd13:   v = 16'sd31356;
            6'd14:   v = 16'sd32137;
            6'd15:   v = 16'sd32609;
            6'd16:   v = 16'sd32767;
            6'd17:   v = 16'sd32609;
            6'd18:   v = 16'sd32137;
            6'd19:   v = 16'sd31356;
            6'd20:   v = 16'sd30273;
            6'd21:   v = 16'sd28898;
            6'd22:   v = 16'sd27245;
            6'd23:   v = 16'sd25329;
            6'd24:   v = 16'sd23170;
            6'd25:   v = 16'sd20787;
            6'd26:   v = 16'sd18204;
            6'd27:   v = 16'sd15446;
            6'd28:   v = 16'sd12539;
            6'd29:   v = 16'sd9512;
            6'd30:   v = 16'sd6393;
            6'd31:   v = 16'sd3212;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/sct_lookup.sv
`timescale 1ns / 1ps

module sct_lookup import sct_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_action,
    input  logic [15:0]  i_angle,
    output t_seg         o_seg
);

    t_phase            w_phase;
    logic [SegW-1:0]   w_seg;
    logic [IdxW-1:0]   w_idx0;
    logic [IdxW-1:0]   w_idx1;
    t_value            w_y0;
    t_value            w_y1;
    logic signed [ValueW:0] w_diff_full;

    t_seg r_seg;
    t_seg n_seg;

    // Shift by a quarter turn for cosine, wrapping at 16 bits.
    assign w_phase     = i_action ? (i_angle + QuarterTurn) : i_angle;
    assign w_seg       = w_phase[FracW +: SegW];
    assign w_idx0      = {1'b0, w_seg};
    assign w_idx1      = w_idx0 + IdxW'(1);
    assign w_y0        = sct_half_wave(w_idx0);
    assign w_y1        = sct_half_wave(w_idx1);
    assign w_diff_full = {w_y1[ValueW-1], w_y1} - {w_y0[ValueW-1], w_y0};

    always_comb begin
        n_seg.valid  = i_valid;
        n_seg.negate = w_phase[AngleW-1];
        n_seg.y0     = w_y0;
        n_seg.diff   = w_diff_full[DiffW-1:0];
        n_seg.frac   = w_phase[FracW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
        end else begin
            r_seg.valid <= n_seg.valid;
        end
        r_seg.negate <= n_seg.negate;
        r_seg.y0     <= n_seg.y0;
        r_seg.diff   <= n_seg.diff;
        r_seg.frac   <= n_seg.frac;
    end

    assign o_seg = r_seg;

endmodule

// File: sv/sine_cosine_table_interp_core.sv
`timescale 1ns / 1ps
// Sine/cosine core: table lookup with linear interpolation, Q15 result.
// Request channel: raise start with i_action (0 sine, 1 cosine) and the
// 16-bit phase i_angle, where 32768 steps make pi. A request is taken at
// each rising edge where start is high and busy is low; busy is tied low,
// so a new request may be issued in every cycle.
// Result channel: o_value is shown for exactly one cycle with o_valid high
// and is taken at the edge that ends that cycle. Results leave in request
// order; the receiver cannot hold them off and the core never needs it to.
// Throughput: one result per cycle, through three register stages:
//   stage 1 - phase shift, half-turn fold and two reads of the 33-point table
//   stage 2 - 13 x 11 bit multiply of the table step by the fraction
//   stage 3 - floor shift by 10, add to the base point, optional negate
// Reset (i_rst_n low at a rising edge) drops every request in flight;
// no result appears for it. The core holds no other state.
module sine_cosine_table_interp_core import sct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic signed [15:0]  i_angle,
    output logic                o_valid,
    output logic signed [15:0]  o_value
);

    t_seg  w_seg;
    logic  w_take;

    // Stage 2 registers
    logic   r_s2_valid;
    logic   r_s2_negate;
    t_value r_s2_y0;
    t_prod  r_s2_prod;

    logic signed [DiffW+FracW:0] w_prod_full;

    // Stage 3 registers
    logic   r_valid;
    t_value r_value;
    t_value n_value;

    t_diff  w_step;
    t_value w_res;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    sct_lookup u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_take),
        .i_action (i_action),
        .i_angle  (i_angle),
        .o_seg    (w_seg)
    );

    // Scale the table step by the fraction; the fraction is unsigned.
    assign w_prod_full = w_seg.diff * $signed({1'b0, w_seg.frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= w_seg.valid;
        end
        r_s2_negate <= w_seg.negate;
        r_s2_y0     <= w_seg.y0;
        r_s2_prod   <= w_prod_full[ProdW-1:0];
    end

    // Arithmetic shift right by the fraction width floors toward minus infinity.
    assign w_step = r_s2_prod[ProdW-1:FracW];
    assign w_res  = r_s2_y0 + {{(ValueW-DiffW){w_step[DiffW-1]}}, w_step};

    always_comb begin
        n_value = r_s2_negate ? -w_res : w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s2_valid;
        end
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

`include "sine_cosine_table_interp_core_assert.svh"

    // The core never refuses a request.
    `SCT_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    // Every request yields a result with o_valid high.
    `SCT_ASSERT_AFTER(a_latency, w_take, 3, o_valid, "result missing after request")
    // The interpolated value never reaches the most negative code.
    `SCT_ASSERT_ALWAYS(a_range, !o_valid || (o_value != 16'sh8000), "result out of range")

endmodule
